// ===== hdl/clut_pkg.sv =====
// ----------------------------------------------------------------------------
// clut_pkg: shared types and constants for the curve table interpolator
// Field widths, fixed step counts, command codes, the controller states and
// the control bundle of the serial divider.
// ----------------------------------------------------------------------------
package clut_pkg;

	localparam int PW   = 17;       // point coordinate width, Q1.16
	localparam int IW   = 8;        // table index width
	localparam int SW   = 4;        // point slot width
	localparam int CFW  = 5;        // active point count register width
	localparam int XW   = IW + 16;  // abscissa of an entry, index << 16 / divisor
	localparam int MW   = XW + PW;  // product width
	localparam int CNTW = 5;        // step counter width

	localparam logic [CNTW-1:0] XDIV_STEPS = CNTW'(XW);
	localparam logic [CNTW-1:0] VDIV_STEPS = CNTW'(PW);
	localparam logic [CNTW-1:0] MUL_STEPS  = CNTW'(PW);

	localparam logic [PW-1:0]  Q_ONE       = PW'(65536);
	localparam logic [CFW-1:0] AP_RESET    = CFW'(2);

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XDIV,
		ST_SRD,
		ST_SCMP,
		ST_LD,
		ST_MUL,
		ST_DCHK,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic            load;
		logic [CNTW-1:0] steps;
	} div_ctl_t;

endpackage

// ===== hdl/clut_sdiv.sv =====
// ----------------------------------------------------------------------------
// clut_sdiv: bit-serial restoring divider
// Shifts one dividend bit into the partial remainder per cycle; quotient bits
// enter the low end of the same shift register.
// ----------------------------------------------------------------------------
module clut_sdiv (
	input  logic                    clk,
	input  logic                    arst_n,
	input  clut_pkg::div_ctl_t      ctl,
	input  logic [clut_pkg::PW-1:0] rem_init,
	input  logic [clut_pkg::PW-1:0] divisor,
	input  logic [clut_pkg::XW-1:0] dvd,
	output logic                    done,
	output logic [clut_pkg::XW-1:0] quo,
	output logic [clut_pkg::PW-1:0] rem
);
	import clut_pkg::*;

	logic [PW-1:0]   rem_q;
	logic [PW-1:0]   dsr_q;
	logic [XW-1:0]   sh_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [PW:0]     trial;
	logic [PW:0]     diff;
	logic            ge;

	assign trial = {rem_q, sh_q[XW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (ctl.load) begin
			cnt_q  <= ctl.steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNTW'(1);
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= rem_init;
			dsr_q <= divisor;
			sh_q  <= dvd;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so it fits PW bits
			rem_q <= ge ? diff[PW-1:0] : trial[PW-1:0];
			sh_q  <= {sh_q[XW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/clut_smul.sv =====
// ----------------------------------------------------------------------------
// clut_smul: bit-serial shift-add multiplier
// One multiplier bit per cycle, LSB first; the product shifts right through
// a high/low register pair.
// ----------------------------------------------------------------------------
module clut_smul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [clut_pkg::XW-1:0] a,
	input  logic [clut_pkg::PW-1:0] b,
	output logic                    done,
	output logic [clut_pkg::MW-1:0] prod
);
	import clut_pkg::*;

	logic [XW-1:0]   a_q;
	logic [XW-1:0]   hi_q;
	logic [PW-1:0]   lo_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [XW:0]     sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= MUL_STEPS;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNTW'(1);
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (cnt_q != '0) begin
			hi_q <= sum[XW:1];
			lo_q <= {sum[0], lo_q[PW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

// ===== hdl/curve_lut_interpolator.sv =====
// ----------------------------------------------------------------------------
// curve_lut_interpolator: piecewise-linear curve table generator
// Sequence: a lookup divides the index into x, then scans the segments
//   (0 .. MAX_POINTS-2) with one memory read per searched point, then
//   multiplies and divides for the slope term; a zero-width segment skips
//   both, and a saturating slope term skips the divide. One lookup at a time;
//   point writes leave the controller idle.
// Reset: controller idle, active_points = 2, point store left undefined.
// ----------------------------------------------------------------------------
module curve_lut_interpolator #(
	parameter int MAX_POINTS  = 16,
	parameter int LUT_ENTRIES = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command channel
	input  logic                     start,
	output logic                     busy,
	input  logic                     cmd,
	input  logic [clut_pkg::SW-1:0]  point_slot,
	input  logic [clut_pkg::PW-1:0]  point_x,
	input  logic [clut_pkg::PW-1:0]  point_y,
	input  logic [clut_pkg::IW-1:0]  entry_index,
	// result strobe
	output logic                     done,
	output logic [clut_pkg::IW-1:0]  entry_echo,
	output logic [clut_pkg::PW-1:0]  entry_value,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [clut_pkg::CFW-1:0] active_points
);
	import clut_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [PW-1:0] LUT_DIV = PW'(LUT_ENTRIES - 1);

	// ---------------------------------------------------------------- control
	state_t state_q, state_d;

	logic accept;
	logic wr_en;
	logic [CFW-1:0] ap_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign wr_en     = accept && (cmd == CMD_WRITE) && (32'(point_slot) < MAX_POINTS);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_q <= AP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ap_q <= active_points;
		end
	end

	// segment limit: points in use minus two, count clamped to 2..MAX_POINTS
	logic [8:0] lim_w;
	always_comb begin
		if (ap_q < CFW'(2)) begin
			lim_w = '0;
		end else if (32'(ap_q) > MAX_POINTS) begin
			lim_w = 9'(MAX_POINTS - 2);
		end else begin
			lim_w = 9'(ap_q) - 9'd2;
		end
	end

	// ----------------------------------------------------------- point store
	logic [2*PW-1:0] mem [MAX_POINTS];
	logic [2*PW-1:0] rd_q;
	logic [AW-1:0]   rd_addr;
	logic [PW-1:0]   rd_x;
	logic [PW-1:0]   rd_y;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(point_slot)] <= {point_x, point_y};
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_x = rd_q[2*PW-1:PW];
	assign rd_y = rd_q[PW-1:0];

	// ------------------------------------------------------- serial datapath
	div_ctl_t       div_ctl;
	logic [PW-1:0]  div_rem_init;
	logic [PW-1:0]  div_divisor;
	logic [XW-1:0]  div_dvd;
	logic           div_done;
	logic [XW-1:0]  div_quo;
	logic [PW-1:0]  div_rem;

	logic           mul_load;
	logic [XW-1:0]  mul_a;
	logic [PW-1:0]  mul_b;
	logic           mul_done;
	logic [MW-1:0]  mul_prod;

	clut_sdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.rem_init (div_rem_init),
		.divisor  (div_divisor),
		.dvd      (div_dvd),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	clut_smul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (mul_load),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// working registers of one lookup
	logic [IW-1:0] idx_q;
	logic [AW-1:0] lim_q;
	logic [AW-1:0] seg_q;
	logic [XW-1:0] x_q;
	logic [PW-1:0] x1_q, y1_q, y0_q, d_q;
	logic          neg_q, dz_q, ovf_q;

	// search step: carry on while segment is not last and x lies right of x1
	logic s_cont;
	logic [AW:0] seg_p1, seg_p2;

	assign s_cont = (seg_q < lim_q) && (x_q > {{(XW-PW){1'b0}}, rd_x});
	assign seg_p1 = {1'b0, seg_q} + (AW+1)'(1);
	assign seg_p2 = {1'b0, seg_q} + (AW+1)'(2);

	// differences against the left point, read back in ST_LD
	logic [XW:0] ex, ex_abs;
	logic [PW:0] ey, ey_abs, edx, edx_abs;

	assign ex      = {1'b0, x_q} - {{(XW-PW+1){1'b0}}, rd_x};
	assign ex_abs  = ex[XW] ? ((XW+1)'(0) - ex) : ex;
	assign ey      = {1'b0, y1_q} - {1'b0, rd_y};
	assign ey_abs  = ey[PW] ? ((PW+1)'(0) - ey) : ey;
	assign edx     = {1'b0, x1_q} - {1'b0, rd_x};
	assign edx_abs = edx[PW] ? ((PW+1)'(0) - edx) : edx;

	assign mul_a = ex_abs[XW-1:0];
	assign mul_b = ey_abs[PW-1:0];

	// slope term too large for any in-range answer
	logic ovf_w;
	assign ovf_w = (mul_prod[MW-1:PW] >= {{(XW-PW){1'b0}}, d_q});

	// final value: y0 plus floored quotient, saturated
	logic [PW:0]   qq;
	logic [PW:0]   acc;
	logic [PW-1:0] fin_val;

	always_comb begin
		qq  = {1'b0, div_quo[PW-1:0]} + (PW+1)'(div_rem != '0);
		acc = '0;
		if (dz_q) begin
			acc = {1'b0, y0_q};
		end else if (ovf_q) begin
			acc = neg_q ? '0 : {1'b0, Q_ONE};
		end else if (neg_q) begin
			acc = ({1'b0, y0_q} < qq) ? '0 : ({1'b0, y0_q} - qq);
		end else begin
			acc = {1'b0, y0_q} + {1'b0, div_quo[PW-1:0]};
		end
		fin_val = (acc > {1'b0, Q_ONE}) ? Q_ONE : acc[PW-1:0];
	end

	// ------------------------------------------------------------ next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_LOOKUP)) state_d = ST_XDIV;
			end
			ST_XDIV: begin
				if (div_done) state_d = ST_SRD;
			end
			ST_SRD:  state_d = ST_SCMP;
			ST_SCMP: begin
				if (!s_cont) state_d = ST_LD;
			end
			ST_LD: begin
				state_d = (edx == '0) ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				if (mul_done) state_d = ST_DCHK;
			end
			ST_DCHK: begin
				state_d = ovf_w ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_FIN;
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// --------------------------------------------------------------- outputs
	always_comb begin
		div_ctl.load  = 1'b0;
		div_ctl.steps = XDIV_STEPS;
		div_rem_init  = '0;
		div_divisor   = LUT_DIV;
		div_dvd       = {entry_index, 16'd0};
		mul_load      = 1'b0;
		rd_addr       = seg_q;
		case (state_q)
			ST_IDLE: begin
				// x = index * 65536 / (LUT_ENTRIES - 1)
				div_ctl.load = accept && (cmd == CMD_LOOKUP);
			end
			ST_SRD: begin
				rd_addr = seg_p1[AW-1:0];
			end
			ST_SCMP: begin
				// fetch the next right point ahead, or the left point on a stop
				rd_addr = s_cont ? seg_p2[AW-1:0] : seg_q;
			end
			ST_LD: begin
				mul_load = (edx != '0);
			end
			ST_DCHK: begin
				// high half is below the divisor, so it is the first remainder
				div_ctl.load  = !ovf_w;
				div_ctl.steps = VDIV_STEPS;
				div_rem_init  = mul_prod[2*PW-1:PW];
				div_divisor   = d_q;
				div_dvd       = {mul_prod[PW-1:0], {(XW-PW){1'b0}}};
			end
			default: begin
			end
		endcase
	end

	// ----------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q <= entry_index;
					lim_q <= AW'(lim_w);
				end
			end
			ST_XDIV: begin
				if (div_done) begin
					x_q   <= div_quo;
					seg_q <= '0;
				end
			end
			ST_SCMP: begin
				if (s_cont) begin
					seg_q <= seg_p1[AW-1:0];
				end else begin
					x1_q <= rd_x;
					y1_q <= rd_y;
				end
			end
			ST_LD: begin
				y0_q  <= rd_y;
				d_q   <= edx_abs[PW-1:0];
				dz_q  <= (edx == '0);
				neg_q <= ex[XW] ^ ey[PW] ^ edx[PW];
			end
			ST_DCHK: begin
				ovf_q <= ovf_w;
			end
			default: begin
			end
		endcase
	end

	// result beat: one cycle strobe, payload held until the next one
	logic          done_q;
	logic [IW-1:0] echo_q;
	logic [PW-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			echo_q  <= idx_q;
			value_q <= fin_val;
		end
	end

	assign done        = done_q;
	assign entry_echo  = echo_q;
	assign entry_value = value_q;

	// ------------------------------------------------------------ assertions
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_LOOKUP)) |=> busy)
		else $error("lookup beat did not start the controller");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_WRITE)) |=> !busy && !done)
		else $error("point write left the controller busy or gave a result");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_value <= Q_ONE))
		else $error("result beyond saturation limit");

	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCMP) |-> (seg_q <= lim_q))
		else $error("segment search ran past the last segment");

endmodule
